@@ sv/rtsp_pkg.sv @@
// Shared constants for the reference-counted tile slot pool.
// Field widths, command, status and register codes, address constants.
// No dependencies.
package rtsp_pkg;

  localparam int CMD_W        = 2;
  localparam int TILE_W       = 13;
  localparam int FLIP_W       = 2;
  localparam int MAP_W        = 12;
  localparam int STATUS_W     = 2;
  localparam int SRC_W        = 32;
  localparam int DEST_W       = 27;
  localparam int COUNT_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int SLOT_FIELD_W = 10;
  localparam int TILE_SH      = 6;   // 64 bytes per tile
  localparam int BLOCK_SH     = 14;  // 16 KiB per character block

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_RES  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE   = 2'd1;

  localparam logic [DEST_W-1:0]  VIDEO_BASE = 27'h6000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

endpackage

@@ sv/refcounted_tile_slot_pool.sv @@
// Reference-counted tile slot pool: tile map, use counts and free stack in RAMs.
// Depends on rtsp_pkg and rtsp_ram.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, command, tile, flip     | in
//  out     | out_valid_o/out_ready_i, map_entry, status,    | out
//          | copy_request, copy_source, copy_dest           |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// One word at a time. A word steps through a tile map read, then for a new
// tile a free stack read, then a count read-modify-write, each through a RAM
// with registered read data.
// A tile number at or above SOURCE_TILES is first reduced modulo SOURCE_TILES:
// a reciprocal multiply for the quotient, then the remainder.
// After reset, and for a clear word, a sweep over max(SOURCE_TILES, SLOT_COUNT)
// addresses rewrites all three RAMs; no word is taken meanwhile.
// A result waiting at the output stalls only the final step of the next word.
module refcounted_tile_slot_pool #(
  parameter int SOURCE_TILES = 8192,
  parameter int SLOT_COUNT   = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rtsp_pkg::CMD_W-1:0]      command_i,
  input  logic [rtsp_pkg::TILE_W-1:0]     tile_number_i,
  input  logic [rtsp_pkg::FLIP_W-1:0]     flip_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rtsp_pkg::MAP_W-1:0]      map_entry_o,
  output logic [rtsp_pkg::STATUS_W-1:0]   status_o,
  output logic                            copy_request_o,
  output logic [rtsp_pkg::SRC_W-1:0]      copy_source_o,
  output logic [rtsp_pkg::DEST_W-1:0]     copy_dest_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rtsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rtsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int TW      = $clog2(SOURCE_TILES);
  localparam int SW      = $clog2(SLOT_COUNT);
  localparam int TOPW    = $clog2(SLOT_COUNT + 1);
  localparam int CLR_N   = (SOURCE_TILES > SLOT_COUNT) ? SOURCE_TILES : SLOT_COUNT;
  localparam int CLR_W   = $clog2(CLR_N);
  // quotient by reciprocal, exact for every tile number below 2^TILE_W
  localparam int RSH     = rtsp_pkg::TILE_W + TW;
  localparam int RCP     = ((1 << RSH) + SOURCE_TILES - 1) / SOURCE_TILES;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_STACK = 3'd4;
  localparam logic [2:0] S_COUNT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_REM   = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [rtsp_pkg::CMD_W-1:0]     cmd_q, cmd_d;
  logic [rtsp_pkg::FLIP_W-1:0]    flip_q, flip_d;
  logic [rtsp_pkg::TILE_W-1:0]    tile_q, tile_d;
  logic [SW-1:0]                  slot_q, slot_d;
  logic                           alloc_q, alloc_d;
  logic [TOPW-1:0]                top_q, top_d;
  logic [rtsp_pkg::TILE_W-1:0]    quot_q, quot_d;
  logic [CLR_W-1:0]               clr_idx_q, clr_idx_d;
  logic                           clr_res_q, clr_res_d;
  logic [rtsp_pkg::STATUS_W-1:0]  pend_status_q, pend_status_d;

  logic [1:0]                     cbb_q;
  logic [rtsp_pkg::SRC_W-1:0]     src_base_q;

  // tile map RAM: {resident, slot}
  logic          tm_we, tm_re;
  logic [TW-1:0] tm_waddr, tm_raddr;
  logic [SW:0]   tm_wdata, tm_rdata;
  // use count RAM
  logic                        cm_we, cm_re;
  logic [SW-1:0]               cm_waddr, cm_raddr;
  logic [rtsp_pkg::COUNT_W-1:0] cm_wdata, cm_rdata;
  // free slot stack RAM
  logic          sm_we, sm_re;
  logic [SW-1:0] sm_waddr, sm_raddr, sm_wdata, sm_rdata;

  logic                            out_valid_q;
  logic [rtsp_pkg::MAP_W-1:0]      map_q;
  logic [rtsp_pkg::STATUS_W-1:0]   status_q;
  logic                            req_q;
  logic [rtsp_pkg::SRC_W-1:0]      src_q;
  logic [rtsp_pkg::DEST_W-1:0]     dest_q;

  logic                            out_free, out_load;
  logic [rtsp_pkg::MAP_W-1:0]      ld_map;
  logic [rtsp_pkg::STATUS_W-1:0]   ld_status;
  logic                            ld_req;
  logic [rtsp_pkg::SRC_W-1:0]      ld_src;
  logic [rtsp_pkg::DEST_W-1:0]     ld_dest;

  logic                            disp_go;
  logic [rtsp_pkg::CMD_W-1:0]      disp_cmd;
  logic [rtsp_pkg::TILE_W-1:0]     disp_tile;
  logic [31:0]                     mod_prod;
  logic [31:0]                     mod_rem;
  logic [rtsp_pkg::COUNT_W-1:0]    cnt_dec;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  rtsp_ram #(.WIDTH(SW + 1), .DEPTH(SOURCE_TILES)) u_tile_map (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (tm_wdata),
    .re_i    (tm_re),
    .raddr_i (tm_raddr),
    .rdata_o (tm_rdata)
  );

  rtsp_ram #(.WIDTH(rtsp_pkg::COUNT_W), .DEPTH(SLOT_COUNT)) u_use_count (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .re_i    (cm_re),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  rtsp_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .re_i    (sm_re),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    flip_d        = flip_q;
    tile_d        = tile_q;
    slot_d        = slot_q;
    alloc_d       = alloc_q;
    top_d         = top_q;
    quot_d        = quot_q;
    clr_idx_d     = clr_idx_q;
    clr_res_d     = clr_res_q;
    pend_status_d = pend_status_q;

    tm_we = 1'b0; tm_waddr = '0; tm_wdata = '0; tm_re = 1'b0; tm_raddr = '0;
    cm_we = 1'b0; cm_waddr = '0; cm_wdata = '0; cm_re = 1'b0; cm_raddr = '0;
    sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0; sm_re = 1'b0; sm_raddr = '0;

    out_load  = 1'b0;
    ld_map    = '0;
    ld_status = rtsp_pkg::STATUS_OK;
    ld_req    = 1'b0;
    ld_src    = '0;
    ld_dest   = '0;

    disp_go   = 1'b0;
    disp_cmd  = cmd_q;
    disp_tile = tile_q;
    mod_prod  = 32'(tile_q) * 32'(RCP);
    mod_rem   = 32'(tile_q) - 32'(quot_q) * 32'(SOURCE_TILES);
    cnt_dec   = cm_rdata - 1'b1;

    case (state_q)
      S_CLEAR: begin
        tm_we    = (32'(clr_idx_q) < SOURCE_TILES);
        tm_waddr = TW'(clr_idx_q);
        tm_wdata = '0;
        cm_we    = (32'(clr_idx_q) < SLOT_COUNT);
        cm_waddr = SW'(clr_idx_q);
        cm_wdata = '0;
        sm_we    = cm_we;
        sm_waddr = SW'(clr_idx_q);
        sm_wdata = SW'(SLOT_COUNT - 1) - SW'(clr_idx_q);
        if (clr_idx_q == CLR_W'(CLR_N - 1)) begin
          top_d         = '0;
          clr_res_d     = 1'b0;
          pend_status_d = rtsp_pkg::STATUS_OK;
          state_d       = clr_res_q ? S_DONE : S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          flip_d = flip_bits_i;
          tile_d = tile_number_i;
          if (32'(tile_number_i) >= SOURCE_TILES) begin
            state_d = S_MOD;
          end else begin
            disp_go   = 1'b1;
            disp_cmd  = command_i;
            disp_tile = tile_number_i;
          end
        end
      end
      S_MOD: begin
        quot_d  = rtsp_pkg::TILE_W'(mod_prod >> RSH);
        state_d = S_REM;
      end
      S_REM: begin
        tile_d    = rtsp_pkg::TILE_W'(mod_rem);
        disp_go   = 1'b1;
        disp_tile = rtsp_pkg::TILE_W'(mod_rem);
      end
      S_LOOK: begin
        slot_d  = tm_rdata[SW-1:0];
        alloc_d = 1'b0;
        if (tm_rdata[SW]) begin
          cm_re    = 1'b1;
          cm_raddr = tm_rdata[SW-1:0];
          state_d  = S_COUNT;
        end else if (cmd_q == rtsp_pkg::CMD_RELEASE) begin
          pend_status_d = rtsp_pkg::STATUS_NOT_RES;
          state_d       = S_DONE;
        end else if (32'(top_q) >= SLOT_COUNT) begin
          pend_status_d = rtsp_pkg::STATUS_NO_SLOT;
          state_d       = S_DONE;
        end else begin
          sm_re    = 1'b1;
          sm_raddr = SW'(top_q);
          state_d  = S_STACK;
        end
      end
      S_STACK: begin
        slot_d   = sm_rdata;
        alloc_d  = 1'b1;
        cm_re    = 1'b1;
        cm_raddr = sm_rdata;
        state_d  = S_COUNT;
      end
      S_COUNT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (cmd_q == rtsp_pkg::CMD_ACQUIRE) begin
            if (!alloc_q && cm_rdata == rtsp_pkg::COUNT_MAX) begin
              ld_status = rtsp_pkg::STATUS_OVERFLOW;
            end else begin
              cm_we    = 1'b1;
              cm_waddr = slot_q;
              cm_wdata = cm_rdata + 1'b1;
              ld_map   = {flip_q, rtsp_pkg::SLOT_FIELD_W'(slot_q)};
              if (alloc_q) begin
                top_d    = top_q + 1'b1;
                tm_we    = 1'b1;
                tm_waddr = TW'(tile_q);
                tm_wdata = {1'b1, slot_q};
                ld_req   = 1'b1;
                ld_src   = src_base_q + (32'(tile_q) << rtsp_pkg::TILE_SH);
                ld_dest  = rtsp_pkg::VIDEO_BASE
                         + (rtsp_pkg::DEST_W'(cbb_q) << rtsp_pkg::BLOCK_SH)
                         + (rtsp_pkg::DEST_W'(slot_q) << rtsp_pkg::TILE_SH);
              end
            end
          end else begin
            cm_we    = 1'b1;
            cm_waddr = slot_q;
            cm_wdata = cnt_dec;
            if (cnt_dec == '0) begin
              // last user gone: slot back on the stack, tile unmapped
              if (top_q != '0) begin
                top_d    = top_q - 1'b1;
                sm_we    = 1'b1;
                sm_waddr = SW'(top_q - 1'b1);
                sm_wdata = slot_q;
              end
              tm_we    = 1'b1;
              tm_waddr = TW'(tile_q);
              tm_wdata = '0;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = pend_status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (disp_go) begin
      case (disp_cmd)
        rtsp_pkg::CMD_ACQUIRE, rtsp_pkg::CMD_RELEASE: begin
          tm_re    = 1'b1;
          tm_raddr = TW'(disp_tile);
          state_d  = S_LOOK;
        end
        rtsp_pkg::CMD_CLEAR: begin
          clr_idx_d = '0;
          clr_res_d = 1'b1;
          state_d   = S_CLEAR;
        end
        default: begin
          pend_status_d = rtsp_pkg::STATUS_OK;
          state_d       = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cmd_q         <= rtsp_pkg::CMD_ACQUIRE;
      alloc_q       <= 1'b0;
      top_q         <= '0;
      quot_q        <= '0;
      clr_idx_q     <= '0;
      clr_res_q     <= 1'b0;
      pend_status_q <= rtsp_pkg::STATUS_OK;
      out_valid_q   <= 1'b0;
      cbb_q         <= '0;
      src_base_q    <= '0;
    end else begin
      state_q       <= state_d;
      cmd_q         <= cmd_d;
      alloc_q       <= alloc_d;
      top_q         <= top_d;
      quot_q        <= quot_d;
      clr_idx_q     <= clr_idx_d;
      clr_res_q     <= clr_res_d;
      pend_status_q <= pend_status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rtsp_pkg::CFG_CHAR_BLOCK: cbb_q      <= cfg_data_i[1:0];
          rtsp_pkg::CFG_SRC_BASE:   src_base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    tile_q <= tile_d;
    slot_q <= slot_d;
    if (out_load) begin
      map_q    <= ld_map;
      status_q <= ld_status;
      req_q    <= ld_req;
      src_q    <= ld_src;
      dest_q   <= ld_dest;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign map_entry_o    = map_q;
  assign status_o       = status_q;
  assign copy_request_o = req_q;
  assign copy_source_o  = src_q;
  assign copy_dest_o    = dest_q;

endmodule

@@ sv/rtsp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data updates only on a read enable and holds otherwise. No dependencies.
module rtsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
